FILE: src/amf_pkg.sv
`timescale 1ns / 1ps
package amf_pkg;

  localparam int SAMPLES    = 7;
  localparam int SampleW    = 16;
  localparam int CountW     = 4;
  localparam int PosW       = 4;
  localparam int IdxW       = $clog2(SAMPLES);
  localparam int DivW       = 16;
  localparam int ValueW     = 24;
  localparam int ProdW      = SampleW + DivW;
  localparam int FracBits   = 8;
  localparam int CfgIndexW  = 1;
  localparam int CfgDataW   = 16;

  localparam logic [DivW-1:0]  DividerReset = DivW'(256);
  localparam logic [ProdW-1:0] RoundHalf    = ProdW'(1) << (FracBits - 1);

  typedef enum logic [1:0] {
    MODE_RAW    = 2'd0,
    MODE_PAD_MV = 2'd1,
    MODE_SCALED = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_NO_GOOD = 2'd2,
    STATUS_BAD_DIV = 2'd3
  } status_t;

  typedef enum logic [CfgIndexW-1:0] {
    REG_CHANNEL_ENABLED = 1'b0,
    REG_DIVIDER_Q8_8    = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_FINISH  = 2'b10
  } state_t;

  // what one cell hands to its right neighbor
  typedef struct packed {
    logic [SampleW-1:0] val;
    logic               gt;
  } amf_link_t;

endpackage

FILE: src/amf_cell.sv
`timescale 1ns / 1ps
module amf_cell (
  input  logic                        clk,
  input  logic                        insert,
  input  logic                        occupied,
  input  logic [amf_pkg::SampleW-1:0] ins_val,
  input  amf_pkg::amf_link_t          left,
  output amf_pkg::amf_link_t          right
);
  import amf_pkg::*;

  logic [SampleW-1:0] val;
  logic               gt;

  assign gt          = occupied && (val > ins_val);
  assign right.val   = val;
  assign right.gt    = gt;

  // a larger entry moves one place up; the first larger entry, else the first empty cell, takes the new sample
  always_ff @(posedge clk) begin
    if (insert && (gt || !occupied)) begin
      val <= left.gt ? left.val : ins_val;
    end
  end

endmodule

FILE: src/adc_median_filter_scaler.sv
`timescale 1ns / 1ps
// Median filter and divider scaler for one converter channel.
// Input: an item (sample, sample_failed, mode) transfers at a rising edge with
// start high and busy low. Items form bursts of SAMPLES; failed samples are
// dropped, good ones are insertion-sorted into a row of cells, one cell per
// buffer entry, in the cycle they arrive.
// Output: after the last sample of a burst, busy is high for one cycle while
// the upper median is selected and, in mode 2, multiplied by divider_q8_8 and
// rounded half up. The next cycle result_valid strobes for one cycle with
// result_value, status and good_count. The receiver cannot stall the block.
// Throughput: one sample per cycle within a burst; between bursts the block holds
// off new samples while busy with the finishing multiply.
// Configuration: cfg_valid/cfg_ready write channel, always ready; index 0 is
// channel_enabled, index 1 is divider_q8_8. Write only while no burst is open.
// Reset (rst, synchronous): burst counters cleared, channel disabled,
// divider 1.0, no result pending. The sorted buffer keeps no reset value.
module adc_median_filter_scaler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [amf_pkg::SampleW-1:0]   sample,
  input  logic                          sample_failed,
  input  logic [1:0]                    mode,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [amf_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [amf_pkg::CfgDataW-1:0]  cfg_data,
  output logic                          result_valid,
  output logic [amf_pkg::ValueW-1:0]    result_value,
  output logic [1:0]                    status,
  output logic [amf_pkg::CountW-1:0]    good_count
);
  import amf_pkg::*;

  state_t              state;
  state_t              state_next;
  logic                channel_enabled;
  logic [DivW-1:0]     divider_q8_8;
  logic [CountW-1:0]   good_samples;
  logic [CountW-1:0]   good_samples_next;
  logic [PosW-1:0]     burst_position;
  logic [PosW-1:0]     burst_position_next;
  logic [1:0]          last_mode;

  logic                accept;
  logic                last;
  logic                insert;
  amf_link_t           link [SAMPLES+1];
  logic [SampleW-1:0]  cell_val [SAMPLES];
  logic [SAMPLES-1:0]  occupied;

  logic [IdxW-1:0]     med_idx;
  logic [SampleW-1:0]  median;
  logic [ProdW-1:0]    product;
  logic [ValueW-1:0]   value_next;
  status_t             status_next;
  logic [CountW-1:0]   count_next;

  assign busy      = (state == ST_FINISH);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign last      = ({1'b0, burst_position} + (PosW+1)'(1)) >= (PosW+1)'(SAMPLES);
  assign insert    = accept && !sample_failed && (good_samples < CountW'(SAMPLES));

  // row of cells, leftmost holds the smallest sample
  assign link[0] = '{val: '0, gt: 1'b0};

  for (genvar i = 0; i < SAMPLES; i++) begin : g_cell
    assign occupied[i] = good_samples > CountW'(i);
    assign cell_val[i] = link[i+1].val;

    amf_cell u_cell (
      .clk      (clk),
      .insert   (insert),
      .occupied (occupied[i]),
      .ins_val  (sample),
      .left     (link[i]),
      .right    (link[i+1])
    );
  end

  always_comb begin
    state_next          = state;
    good_samples_next   = good_samples;
    burst_position_next = burst_position;
    case (state)
      ST_COLLECT: begin
        if (accept) begin
          if (insert) begin
            good_samples_next = good_samples + CountW'(1);
          end
          if (last) begin
            burst_position_next = '0;
            state_next          = ST_FINISH;
          end else begin
            burst_position_next = burst_position + PosW'(1);
          end
        end
      end
      ST_FINISH: begin
        good_samples_next = '0;
        state_next        = ST_COLLECT;
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

  // finishing step: upper median, then optional Q8.8 scale
  assign med_idx = IdxW'(good_samples >> 1);
  assign median  = cell_val[med_idx];
  assign product = ProdW'(median) * ProdW'(divider_q8_8) + RoundHalf;

  always_comb begin
    status_next = STATUS_OK;
    value_next  = '0;
    count_next  = good_samples;
    if (!channel_enabled) begin
      status_next = STATUS_INVALID;
      count_next  = '0;
    end else if (good_samples == '0) begin
      status_next = STATUS_NO_GOOD;
    end else if (last_mode == MODE_SCALED) begin
      if (divider_q8_8 == '0) begin
        status_next = STATUS_BAD_DIV;
      end else begin
        value_next = product[FracBits +: ValueW];
      end
    end else begin
      value_next = ValueW'(median);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_COLLECT;
      good_samples    <= '0;
      burst_position  <= '0;
      channel_enabled <= 1'b0;
      divider_q8_8    <= DividerReset;
      result_valid    <= 1'b0;
    end else begin
      state          <= state_next;
      good_samples   <= good_samples_next;
      burst_position <= burst_position_next;
      result_valid   <= busy;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CHANNEL_ENABLED: channel_enabled <= cfg_data[0];
          REG_DIVIDER_Q8_8:    divider_q8_8    <= cfg_data[DivW-1:0];
          default: ;
        endcase
      end
    end
  end

  // hold the mode of the burst's last sample; load the result on the finish cycle
  always_ff @(posedge clk) begin
    if (accept && last) begin
      last_mode <= mode;
    end
    if (busy) begin
      result_value <= value_next;
      status       <= status_next;
      good_count   <= count_next;
    end
  end

endmodule

FILE: src/amf_checker.sv
`timescale 1ns / 1ps
module amf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          busy,
  input logic                          result_valid,
  input logic [amf_pkg::ValueW-1:0]    result_value,
  input logic [1:0]                    status,
  input logic [amf_pkg::CountW-1:0]    good_count
);
  import amf_pkg::*;

  // finish step lasts one cycle and always ends in a result
  a_finish_then_result: assert property (@(posedge clk) disable iff (rst)
    busy |=> (!busy && result_valid))
    else $error("finish cycle not followed by a result");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  a_error_zero_value: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status != STATUS_OK)) |-> (result_value == '0))
    else $error("nonzero value with error status");

  a_no_count_on_empty: assert property (@(posedge clk) disable iff (rst)
    (result_valid && ((status == STATUS_INVALID) || (status == STATUS_NO_GOOD)))
      |-> (good_count == '0))
    else $error("nonzero count with invalid channel or no good samples");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (good_count <= CountW'(SAMPLES)))
    else $error("good count beyond burst length");

endmodule

bind adc_median_filter_scaler amf_checker u_amf_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import amf_pkg::*;

  localparam int IdleLimit = 1000;

  typedef struct {
    logic [SampleW-1:0] smp;
    logic               bad;
    logic [1:0]         md;
  } conv_item_t;

  typedef struct {
    logic [ValueW-1:0] value;
    status_t           st;
    logic [CountW-1:0] cnt;
  } median_exp_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [SampleW-1:0]   sample = '0;
  logic                 sample_failed = 1'b0;
  logic [1:0]           mode = 2'd0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;
  logic                 result_valid;
  logic [ValueW-1:0]    result_value;
  logic [1:0]           status;
  logic [CountW-1:0]    good_count;

  adc_median_filter_scaler DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .sample(sample),
    .sample_failed(sample_failed),
    .mode(mode),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .result_value(result_value),
    .status(status),
    .good_count(good_count)
  );

  conv_item_t  conv_queue[$];
  conv_item_t  next_conv;
  median_exp_t medians_due[$];

  // predictor state
  logic [SampleW-1:0] sorted_keep[SAMPLES];
  int                 kept;
  int                 slot;
  logic               chan_on;
  logic [DivW-1:0]    div_ratio;

  logic sample_taken = 1'b0;
  int   gap_left = 0;
  bit   steady = 1'b0;
  int   idle_cycles = 0;
  int   fail_count = 0;
  int   conversions = 0;
  int   bursts_checked = 0;
  int   cfg_writes = 0;
  int   status_seen[4] = '{0, 0, 0, 0};

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // insert one conversion, close the burst on its last slot
  task automatic absorb_conversion(input conv_item_t it);
    median_exp_t     e;
    logic [SampleW-1:0] mid;
    logic [32:0]     prod;
    int              k;
    if (!it.bad && kept < SAMPLES) begin
      k = kept;
      while (k > 0 && sorted_keep[k-1] > it.smp) begin
        sorted_keep[k] = sorted_keep[k-1];
        k--;
      end
      sorted_keep[k] = it.smp;
      kept++;
    end
    if (slot + 1 < SAMPLES) begin
      slot++;
    end else begin
      e.value = '0;
      e.st    = STATUS_OK;
      e.cnt   = CountW'(kept);
      if (!chan_on) begin
        e.st  = STATUS_INVALID;
        e.cnt = '0;
      end else if (kept == 0) begin
        e.st = STATUS_NO_GOOD;
      end else begin
        mid = sorted_keep[kept / 2];
        if (it.md == MODE_SCALED) begin
          if (div_ratio == '0) begin
            e.st = STATUS_BAD_DIV;
          end else begin
            prod    = 33'(mid) * 33'(div_ratio) + 33'd128;
            e.value = prod[31:8];
          end
        end else begin
          e.value = ValueW'(mid);
        end
      end
      medians_due.push_back(e);
      kept = 0;
      slot = 0;
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else if (!start || sample_taken) begin
      if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (conv_queue.size() > 0) begin
        next_conv = conv_queue.pop_front();
        sample        <= next_conv.smp;
        sample_failed <= next_conv.bad;
        mode          <= next_conv.md;
        start         <= 1'b1;
        gap_left      <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    median_exp_t e;
    conv_item_t  it;
    sample_taken <= start && !busy && !rst;
    if (rst) begin
      kept      = 0;
      slot      = 0;
      chan_on   = 1'b0;
      div_ratio = DividerReset;
    end else begin
      // a result leaving now belongs to an earlier burst: check it first
      if (result_valid) begin
        if (medians_due.size() == 0) begin
          $display("%0t: unexpected result value %0h status %0d count %0d",
                   $time, result_value, status, good_count);
          fail_count++;
        end else begin
          e = medians_due.pop_front();
          bursts_checked++;
          status_seen[e.st]++;
          if (result_value !== e.value) begin
            $display("%0t: result_value expected %0h actual %0h", $time, e.value, result_value);
            fail_count++;
          end
          if (status !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, status);
            fail_count++;
          end
          if (good_count !== e.cnt) begin
            $display("%0t: good_count expected %0d actual %0d", $time, e.cnt, good_count);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CHANNEL_ENABLED: chan_on = cfg_data[0];
          REG_DIVIDER_Q8_8:    div_ratio = cfg_data;
          default: ;
        endcase
        cfg_writes++;
      end
      if (start && !busy) begin
        it.smp = sample;
        it.bad = sample_failed;
        it.md  = mode;
        absorb_conversion(it);
        conversions++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IdleLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, IdleLimit, medians_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_conv(input logic [SampleW-1:0] smp, input logic bad,
                           input logic [1:0] md);
    conv_item_t it;
    it.smp = smp;
    it.bad = bad;
    it.md  = md;
    conv_queue.push_back(it);
  endtask

  task automatic queue_burst();
    conv_item_t it;
    int style;
    int fail_pct;
    style    = $urandom_range(99);
    fail_pct = (style < 8) ? 100 : (style < 25) ? 75 : 15;
    for (int i = 0; i < SAMPLES; i++) begin
      if (style >= 25 && style < 40) begin
        it.smp = $urandom_range(1) ? 16'hFFFF - 16'($urandom_range(1)) : 16'($urandom_range(1));
      end else if (style >= 40 && style < 55) begin
        // narrow range to force equal keys
        it.smp = 16'($urandom_range(4));
      end else begin
        it.smp = 16'($urandom);
      end
      it.bad = ($urandom_range(99) < fail_pct);
      if (i == SAMPLES - 1 && $urandom_range(1)) begin
        it.md = MODE_SCALED;
      end else begin
        it.md = 2'($urandom_range(3));
      end
      conv_queue.push_back(it);
    end
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CfgDataW-1:0] data);
    int n;
    n = cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (cfg_writes == n);
    cfg_valid <= 1'b0;
  endtask

  // hold the sender until every open burst has reported
  task automatic settle();
    while (conv_queue.size() > 0 || start || medians_due.size() > 0 || slot != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    logic [CfgDataW-1:0] div_plan[8];
    bit                  en_plan[8];
    div_plan = '{16'h0000, 16'hFFFF, 16'h0180, 16'h0001, 16'h0000, 16'h0080, 16'h0000, 16'h0100};
    en_plan  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
    div_plan[4] = 16'($urandom);
    div_plan[6] = 16'($urandom);
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // channel still disabled after reset: burst consumed, invalid reported
    for (int i = 0; i < SAMPLES; i++) push_conv(16'($urandom), 1'b0, MODE_SCALED);
    settle();
    write_reg(REG_CHANNEL_ENABLED, 16'hFFFF);

    // full-scale and zero samples, one dropped, scaled by the reset divider
    push_conv(16'hFFFF, 1'b0, MODE_RAW);
    push_conv(16'h0000, 1'b0, MODE_PAD_MV);
    push_conv(16'hFFFF, 1'b0, MODE_RAW);
    push_conv(16'h1234, 1'b1, MODE_RAW);
    push_conv(16'h0000, 1'b0, MODE_PAD_MV);
    push_conv(16'hFFFF, 1'b0, MODE_RAW);
    push_conv(16'h8000, 1'b0, MODE_SCALED);
    // every conversion failed
    for (int i = 0; i < SAMPLES; i++) push_conv(16'hFFFF >> i, 1'b1, MODE_PAD_MV);
    // single good sample, unused mode code closes the burst
    for (int i = 0; i < SAMPLES - 1; i++) push_conv(16'h5555, 1'b1, MODE_SCALED);
    push_conv(16'hA5A5, 1'b0, 2'd3);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_CHANNEL_ENABLED, {15'($urandom), en_plan[ph]});
      write_reg(REG_DIVIDER_Q8_8, div_plan[ph]);
      steady = (ph % 3 == 1);
      for (int b = 0; b < 16; b++) queue_burst();
      settle();
    end

    steady = 1'b0;
    settle();
    $display("Checked %0d bursts from %0d conversions across %0d register writes",
             bursts_checked, conversions, cfg_writes);
    $display("Status mix: ok %0d, channel invalid %0d, no good %0d, bad divider %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: adc_median_filter_scaler.f
src/amf_pkg.sv
src/amf_cell.sv
src/adc_median_filter_scaler.sv
src/amf_checker.sv
bench/tb.sv
